// ----- rtl/mrcse_pkg.sv -----
// Shared types and constants for the matrix row/column sum and extrema block.
// No dependencies.
package mrcse_pkg;

    localparam int DEFAULT_MATRIX_DIM = 8;
    localparam int ELEM_W             = 16;
    localparam int SUM_W              = 22;
    localparam int KIND_W             = 2;
    localparam int OUT_IDX_W          = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ROW     = 2'd0,
        KIND_COL     = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_COLS,
        ST_SUMMARY
    } state_t;

    // shift: move the ring one place toward the head; add: fold the element in.
    typedef struct packed {
        logic shift;
        logic add;
    } ring_ctrl_t;

endpackage

// ----- rtl/mrcse_cell.sv -----
// One column accumulator cell of the rotating accumulator ring.
// Depends on mrcse_pkg.
module mrcse_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mrcse_pkg::ring_ctrl_t               ctrl,
    input  logic signed [mrcse_pkg::SUM_W-1:0]  din,
    input  logic signed [mrcse_pkg::SUM_W-1:0]  addend,
    output logic signed [mrcse_pkg::SUM_W-1:0]  dout
);

    logic signed [mrcse_pkg::SUM_W-1:0] acc_reg;
    logic signed [mrcse_pkg::SUM_W-1:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.shift)
        begin
            acc_next = ctrl.add ? din + addend : din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign dout = acc_reg;

endmodule

// ----- rtl/matrix_row_col_sum_extrema.sv -----
// Row sums, column sums, largest row sum and extreme-element positions of a square matrix.
// A row-end element gives its row sum from the output register in the next cycle; mid-row elements give none.
// Takes one element per cycle unless a row-end element waits on a held output; after the last
// element it takes none while the column sums and summary drain through the output register.
// Reset (rst_n, async, active low) clears all internal sums, positions and the output valid.
// Depends on mrcse_pkg and mrcse_cell.
module matrix_row_col_sum_extrema #(
    parameter int MatrixDim = mrcse_pkg::DEFAULT_MATRIX_DIM
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    elem_valid,
    output logic                                    elem_stall,
    input  logic signed [mrcse_pkg::ELEM_W-1:0]     element_value,
    output logic                                    res_valid,
    input  logic                                    res_stall,
    output logic [mrcse_pkg::KIND_W-1:0]            result_kind,
    output logic [mrcse_pkg::OUT_IDX_W-1:0]         result_index,
    output logic signed [mrcse_pkg::SUM_W-1:0]      sum_value,
    output logic signed [mrcse_pkg::SUM_W-1:0]      largest_row_sum,
    output logic [mrcse_pkg::OUT_IDX_W-1:0]         max_elem_row,
    output logic [mrcse_pkg::OUT_IDX_W-1:0]         max_elem_col,
    output logic [mrcse_pkg::OUT_IDX_W-1:0]         min_elem_row,
    output logic [mrcse_pkg::OUT_IDX_W-1:0]         min_elem_col,
    output logic                                    last_of_run
);

    localparam int IDX_W = $clog2(MatrixDim);
    localparam int SUM_W = mrcse_pkg::SUM_W;
    localparam int OW    = mrcse_pkg::OUT_IDX_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MatrixDim - 1);

    function automatic logic [OW-1:0] idx_out(input logic [IDX_W-1:0] p);
        logic [IDX_W+OW-1:0] e;
        e = {{OW{1'b0}}, p};
        return e[OW-1:0];
    endfunction

    mrcse_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0] row_pos_reg, row_pos_next;
    logic [IDX_W-1:0] col_pos_reg, col_pos_next;
    logic [IDX_W-1:0] drain_reg, drain_next;
    logic signed [SUM_W-1:0] row_accum_reg, row_accum_next;
    logic signed [SUM_W-1:0] best_reg, best_next;
    logic signed [mrcse_pkg::ELEM_W-1:0] max_val_reg, max_val_next;
    logic signed [mrcse_pkg::ELEM_W-1:0] min_val_reg, min_val_next;
    logic [IDX_W-1:0] max_row_reg, max_row_next, max_col_reg, max_col_next;
    logic [IDX_W-1:0] min_row_reg, min_row_next, min_col_reg, min_col_next;

    logic res_valid_reg, res_valid_next;
    logic [mrcse_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [OW-1:0] index_reg, index_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SUM_W-1:0] largest_reg, largest_next;
    logic [OW-1:0] maxr_reg, maxr_next, maxc_reg, maxc_next;
    logic [OW-1:0] minr_reg, minr_next, minc_reg, minc_next;
    logic last_reg, last_next;

    logic out_free, elem_acc, col_last, row_last, first_elem, drain_last;
    logic load_row, load_col, load_summary;
    logic signed [SUM_W-1:0] v_ext, row_sum_new;
    mrcse_pkg::ring_ctrl_t ring_ctrl;
    logic signed [SUM_W-1:0] ring_q [MatrixDim];

    assign out_free   = !res_valid_reg || !res_stall;
    assign col_last   = (col_pos_reg == IDX_LAST);
    assign row_last   = (row_pos_reg == IDX_LAST);
    assign drain_last = (drain_reg == IDX_LAST);
    assign first_elem = (row_pos_reg == '0) && (col_pos_reg == '0);
    assign elem_stall = (state_reg != mrcse_pkg::ST_RUN) || (col_last && !out_free);
    assign elem_acc   = elem_valid && !elem_stall;
    assign v_ext       = SUM_W'(element_value);
    assign row_sum_new = row_accum_reg + v_ext;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrcse_pkg::ST_RUN:
            begin
                if (elem_acc && col_last && row_last)
                begin
                    state_next = mrcse_pkg::ST_COLS;
                end
            end
            mrcse_pkg::ST_COLS:
            begin
                if (out_free && drain_last)
                begin
                    state_next = mrcse_pkg::ST_SUMMARY;
                end
            end
            mrcse_pkg::ST_SUMMARY:
            begin
                if (out_free)
                begin
                    state_next = mrcse_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = mrcse_pkg::ST_RUN;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        load_row     = 1'b0;
        load_col     = 1'b0;
        load_summary = 1'b0;
        ring_ctrl    = '0;
        unique case (state_reg)
            mrcse_pkg::ST_RUN:
            begin
                load_row        = elem_acc && col_last;
                ring_ctrl.shift = elem_acc;
                ring_ctrl.add   = elem_acc;
            end
            mrcse_pkg::ST_COLS:
            begin
                load_col        = out_free;
                ring_ctrl.shift = out_free;
            end
            mrcse_pkg::ST_SUMMARY:
            begin
                load_summary = out_free;
            end
            default:
            begin
                load_row = 1'b0;
            end
        endcase
    end

    // column accumulator ring: head is the current column
    genvar gi;
    generate
        for (gi = 0; gi < MatrixDim; gi++)
        begin : g_cell
            mrcse_pkg::ring_ctrl_t    cell_ctrl;
            logic signed [SUM_W-1:0]  cell_din;
            if (gi == MatrixDim - 1)
            begin : g_tail
                assign cell_ctrl = ring_ctrl;
                assign cell_din  = ring_ctrl.add ? ring_q[0] : '0;
            end
            else
            begin : g_body
                assign cell_ctrl = '{shift: ring_ctrl.shift, add: 1'b0};
                assign cell_din  = ring_q[gi+1];
            end
            mrcse_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (cell_ctrl),
                .din    (cell_din),
                .addend (v_ext),
                .dout   (ring_q[gi])
            );
        end
    endgenerate

    // position, row sum and extrema tracking
    always_comb
    begin
        row_pos_next   = row_pos_reg;
        col_pos_next   = col_pos_reg;
        row_accum_next = row_accum_reg;
        best_next      = best_reg;
        max_val_next   = max_val_reg;
        min_val_next   = min_val_reg;
        max_row_next   = max_row_reg;
        max_col_next   = max_col_reg;
        min_row_next   = min_row_reg;
        min_col_next   = min_col_reg;
        drain_next     = drain_reg;
        if (elem_acc)
        begin
            if (first_elem)
            begin
                max_val_next = element_value;
                min_val_next = element_value;
                max_row_next = '0;
                max_col_next = '0;
                min_row_next = '0;
                min_col_next = '0;
            end
            else
            begin
                if (element_value > max_val_reg)
                begin
                    max_val_next = element_value;
                    max_row_next = row_pos_reg;
                    max_col_next = col_pos_reg;
                end
                if (element_value < min_val_reg)
                begin
                    min_val_next = element_value;
                    min_row_next = row_pos_reg;
                    min_col_next = col_pos_reg;
                end
            end
            if (col_last)
            begin
                if ((row_pos_reg == '0) || (row_sum_new > best_reg))
                begin
                    best_next = row_sum_new;
                end
                row_accum_next = '0;
                col_pos_next   = '0;
                row_pos_next   = row_last ? '0 : row_pos_reg + 1'b1;
            end
            else
            begin
                row_accum_next = row_sum_new;
                col_pos_next   = col_pos_reg + 1'b1;
            end
        end
        if (load_col)
        begin
            drain_next = drain_last ? '0 : drain_reg + 1'b1;
        end
    end

    // output register
    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        kind_next      = kind_reg;
        index_next     = index_reg;
        sum_next       = sum_reg;
        largest_next   = largest_reg;
        maxr_next      = maxr_reg;
        maxc_next      = maxc_reg;
        minr_next      = minr_reg;
        minc_next      = minc_reg;
        last_next      = last_reg;
        if (load_row || load_col || load_summary)
        begin
            res_valid_next = 1'b1;
            largest_next   = '0;
            maxr_next      = '0;
            maxc_next      = '0;
            minr_next      = '0;
            minc_next      = '0;
            last_next      = 1'b0;
            index_next     = '0;
            sum_next       = '0;
        end
        priority if (load_row)
        begin
            kind_next  = mrcse_pkg::KIND_ROW;
            index_next = idx_out(row_pos_reg);
            sum_next   = row_sum_new;
            last_next  = !row_last;
        end
        else if (load_col)
        begin
            kind_next  = mrcse_pkg::KIND_COL;
            index_next = idx_out(drain_reg);
            sum_next   = ring_q[0];
        end
        else if (load_summary)
        begin
            kind_next    = mrcse_pkg::KIND_SUMMARY;
            largest_next = best_reg;
            maxr_next    = idx_out(max_row_reg);
            maxc_next    = idx_out(max_col_reg);
            minr_next    = idx_out(min_row_reg);
            minc_next    = idx_out(min_col_reg);
            last_next    = 1'b1;
        end
        else
        begin
            kind_next = kind_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrcse_pkg::ST_RUN;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            drain_reg     <= '0;
            row_accum_reg <= '0;
            best_reg      <= '0;
            max_val_reg   <= '0;
            min_val_reg   <= '0;
            max_row_reg   <= '0;
            max_col_reg   <= '0;
            min_row_reg   <= '0;
            min_col_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            drain_reg     <= drain_next;
            row_accum_reg <= row_accum_next;
            best_reg      <= best_next;
            max_val_reg   <= max_val_next;
            min_val_reg   <= min_val_next;
            max_row_reg   <= max_row_next;
            max_col_reg   <= max_col_next;
            min_row_reg   <= min_row_next;
            min_col_reg   <= min_col_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        index_reg   <= index_next;
        sum_reg     <= sum_next;
        largest_reg <= largest_next;
        maxr_reg    <= maxr_next;
        maxc_reg    <= maxc_next;
        minr_reg    <= minr_next;
        minc_reg    <= minc_next;
        last_reg    <= last_next;
    end

    assign res_valid       = res_valid_reg;
    assign result_kind     = kind_reg;
    assign result_index    = index_reg;
    assign sum_value       = sum_reg;
    assign largest_row_sum = largest_reg;
    assign max_elem_row    = maxr_reg;
    assign max_elem_col    = maxc_reg;
    assign min_elem_row    = minr_reg;
    assign min_elem_col    = minc_reg;
    assign last_of_run     = last_reg;

endmodule

// ----- tb/matrix_row_col_sum_extrema_tb.sv -----
// Self-checking testbench for matrix_row_col_sum_extrema: streams whole matrices,
// predicts row sums, column sums and the summary request by request, and checks each result.
// Depends on mrcse_pkg and the matrix_row_col_sum_extrema RTL.
module matrix_row_col_sum_extrema_tb;

    localparam int DIM         = mrcse_pkg::DEFAULT_MATRIX_DIM;
    localparam int ELEM_W      = mrcse_pkg::ELEM_W;
    localparam int SUM_W       = mrcse_pkg::SUM_W;
    localparam int KIND_W      = mrcse_pkg::KIND_W;
    localparam int OUT_IDX_W   = mrcse_pkg::OUT_IDX_W;
    localparam int MATRICES    = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 50;

    typedef struct {
        mrcse_pkg::kind_t            kind;
        logic [OUT_IDX_W-1:0]        index;
        logic signed [SUM_W-1:0]     sum;
        logic signed [SUM_W-1:0]     largest;
        logic [OUT_IDX_W-1:0]        max_row;
        logic [OUT_IDX_W-1:0]        max_col;
        logic [OUT_IDX_W-1:0]        min_row;
        logic [OUT_IDX_W-1:0]        min_col;
        logic                        last;
    } sum_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          elem_valid;
    logic                          elem_stall;
    logic signed [ELEM_W-1:0]      element_value;
    logic                          res_valid;
    logic                          res_stall;
    logic [KIND_W-1:0]             result_kind;
    logic [OUT_IDX_W-1:0]          result_index;
    logic signed [SUM_W-1:0]       sum_value;
    logic signed [SUM_W-1:0]       largest_row_sum;
    logic [OUT_IDX_W-1:0]          max_elem_row;
    logic [OUT_IDX_W-1:0]          max_elem_col;
    logic [OUT_IDX_W-1:0]          min_elem_row;
    logic [OUT_IDX_W-1:0]          min_elem_col;
    logic                          last_of_run;

    logic signed [ELEM_W-1:0]      pending_elems[$];
    sum_result_t                   expected_sums[$];

    // predicted block state
    int                            cur_row;
    int                            cur_col;
    logic signed [SUM_W-1:0]       row_total;
    logic signed [SUM_W-1:0]       col_totals[DIM];
    logic signed [SUM_W-1:0]       best_row;
    logic signed [ELEM_W-1:0]      peak_val;
    logic signed [ELEM_W-1:0]      trough_val;
    int                            peak_row;
    int                            peak_col;
    int                            trough_row;
    int                            trough_col;

    int                            error_count = 0;
    int                            cycle_count = 0;
    int                            results_seen = 0;
    int                            burst_left;
    int                            gap_left;
    logic                          take;
    logic                          next_valid;
    int                            hold_cycles;
    int                            hold_count;
    int                            stall_mode;
    int                            mode_left;
    logic                          next_stall;
    sum_result_t                   want;

    matrix_row_col_sum_extrema #(
        .MatrixDim(DIM)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .elem_valid     (elem_valid),
        .elem_stall     (elem_stall),
        .element_value  (element_value),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .result_kind    (result_kind),
        .result_index   (result_index),
        .sum_value      (sum_value),
        .largest_row_sum(largest_row_sum),
        .max_elem_row   (max_elem_row),
        .max_elem_col   (max_elem_col),
        .min_elem_row   (min_elem_row),
        .min_elem_col   (min_elem_col),
        .last_of_run    (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic clear_stats();
        cur_row    = 0;
        cur_col    = 0;
        row_total  = '0;
        best_row   = '0;
        peak_val   = '0;
        trough_val = '0;
        peak_row   = 0;
        peak_col   = 0;
        trough_row = 0;
        trough_col = 0;
        for (int c = 0; c < DIM; c++)
        begin
            col_totals[c] = '0;
        end
    endtask

    task automatic fold_element(input logic signed [ELEM_W-1:0] v);
        sum_result_t r;
        logic        final_row;
        if (cur_row == 0 && cur_col == 0)
        begin
            peak_val   = v;
            peak_row   = 0;
            peak_col   = 0;
            trough_val = v;
            trough_row = 0;
            trough_col = 0;
        end
        else
        begin
            if (v > peak_val)
            begin
                peak_val = v;
                peak_row = cur_row;
                peak_col = cur_col;
            end
            if (v < trough_val)
            begin
                trough_val = v;
                trough_row = cur_row;
                trough_col = cur_col;
            end
        end
        row_total           = row_total + SUM_W'(v);
        col_totals[cur_col] = col_totals[cur_col] + SUM_W'(v);
        if (cur_col + 1 < DIM)
        begin
            cur_col++;
            return;
        end
        if (cur_row == 0 || row_total > best_row)
            best_row = row_total;
        final_row = (cur_row + 1 >= DIM);
        r = '{mrcse_pkg::KIND_ROW, cur_row[OUT_IDX_W-1:0], row_total, '0, '0, '0, '0, '0,
              !final_row};
        expected_sums.push_back(r);
        row_total = '0;
        cur_col   = 0;
        if (!final_row)
        begin
            cur_row++;
            return;
        end
        for (int c = 0; c < DIM; c++)
        begin
            r = '{mrcse_pkg::KIND_COL, c[OUT_IDX_W-1:0], col_totals[c], '0, '0, '0, '0, '0,
                  1'b0};
            expected_sums.push_back(r);
        end
        r = '{mrcse_pkg::KIND_SUMMARY, '0, '0, best_row, peak_row[OUT_IDX_W-1:0],
              peak_col[OUT_IDX_W-1:0], trough_row[OUT_IDX_W-1:0],
              trough_col[OUT_IDX_W-1:0], 1'b1};
        expected_sums.push_back(r);
        clear_stats();
    endtask

    task automatic flag_mismatch(input string msg);
        if (error_count < REPORT_MAX)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int exp_val);
        if (got != exp_val)
            flag_mismatch($sformatf("%s got %0d expected %0d (kind %0d index %0d)",
                                    name, got, exp_val, want.kind, want.index));
    endtask

    // sender: bursts of requests with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_valid    <= 1'b0;
            element_value <= '0;
            burst_left = 0;
            gap_left   = 0;
            clear_stats();
        end
        else
        begin
            take       = elem_valid && !elem_stall;
            next_valid = 1'b0;
            if (take)
            begin
                fold_element(element_value);
                pending_elems.delete(0);
            end
            if (elem_valid && !take)
            begin
                next_valid = 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_elems.size() != 0)
            begin
                next_valid = 1'b1;
                element_value <= pending_elems[0];
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            elem_valid <= next_valid;
        end
    end

    // receiver: stall pattern plus two long hold-offs to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_cycles = 0;
            hold_count  = 0;
            stall_mode  = 0;
            mode_left   = 0;
        end
        else
        begin
            next_stall = 1'b0;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                next_stall = 1'b1;
            end
            else if (hold_count < 2 && results_seen >= ((hold_count == 0) ? 12 : 70))
            begin
                hold_cycles = 150;
                hold_count++;
                next_stall = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(10, 60);
                end
                mode_left--;
                case (stall_mode)
                    1:       next_stall = ($urandom_range(0, 3) == 0);
                    2:       next_stall = !res_stall;
                    3:       next_stall = ($urandom_range(0, 9) != 0);
                    default: next_stall = 1'b0;
                endcase
            end
            res_stall <= next_stall;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen <= results_seen + 1;
            if (expected_sums.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result kind %0d index %0d",
                                        result_kind, result_index));
            end
            else
            begin
                want = expected_sums.pop_front();
                check_field("result_kind", result_kind, want.kind);
                check_field("result_index", result_index, want.index);
                check_field("sum_value", sum_value, want.sum);
                check_field("largest_row_sum", largest_row_sum, want.largest);
                check_field("max_elem_row", max_elem_row, want.max_row);
                check_field("max_elem_col", max_elem_col, want.max_col);
                check_field("min_elem_row", min_elem_row, want.min_row);
                check_field("min_elem_col", min_elem_col, want.min_col);
                check_field("last_of_run", last_of_run, want.last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL matrix_row_col_sum_extrema");
            $finish;
        end
    end

    initial
    begin
        logic signed [ELEM_W-1:0] directed[24];
        logic signed [ELEM_W-1:0] base;
        logic signed [ELEM_W-1:0] v;
        int                       style;
        int                       idx;

        rst_n = 1'b0;

        // extremes, ties across rows, and a row at the most negative sum
        directed = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000, 16'h5555,
                     16'hAAAA, 16'h0000, 16'h7FFF, 16'h8000, 16'h1234, 16'hEDCC, 16'h00FF, 16'hFF00,
                     16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000};

        for (int m = 0; m < MATRICES; m++)
        begin
            case (m)
                0:       style = 0;
                1:       style = 2;
                2:       style = 3;
                default: style = $urandom_range(0, 6);
            endcase
            base = ELEM_W'($urandom);
            for (int r = 0; r < DIM; r++)
            begin
                for (int c = 0; c < DIM; c++)
                begin
                    idx = r * DIM + c;
                    case (style)
                        1:       v = base;
                        2:       v = 16'sh7FFF;
                        3:       v = 16'sh8000;
                        4:       v = ELEM_W'($signed($urandom_range(0, 8)) - 4);
                        5:       v = ELEM_W'(r * 4000 - 16000
                                             + $signed($urandom_range(0, 200)));
                        6:       v = ELEM_W'(16000 - r * 4000
                                             - $signed($urandom_range(0, 200)));
                        default: v = ELEM_W'($urandom);
                    endcase
                    if (m == 0 && idx < 24)
                        v = directed[idx];
                    pending_elems.push_back(v);
                end
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_elems.size() != 0 || elem_valid)
            @(posedge clk);
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (DIM + 8) @(posedge clk);

        if (error_count == 0 && expected_sums.size() == 0)
            $display("PASS matrix_row_col_sum_extrema");
        else
            $display("FAIL matrix_row_col_sum_extrema");
        $finish;
    end

endmodule
